### rtl/vtfb_pkg.sv
package vtfb_pkg;

    localparam int IN_FRAC_BITS  = 16;
    localparam int OUT_FRAC_BITS = 14;

    localparam int IN_W     = 32;
    localparam int OUT_W    = 16;
    localparam int MAG_W    = 32;
    localparam int NRM_TOP  = 30;
    localparam int SCL_W    = NRM_TOP + 1;
    localparam int RED_TOP  = 19;
    localparam int RED_W    = RED_TOP + 2;
    localparam int QW       = OUT_FRAC_BITS + 1;
    localparam int NW       = OUT_FRAC_BITS + 33;
    localparam int SQ_STEPS = 32;
    localparam int TINY_W   = 12;

    // A vector is tiny when its raw sum of squares is at most this.
    localparam logic [63:0] TINY_SQ = 64'((64'd1 << (2 * IN_FRAC_BITS)) / 64'd100000000);

    // 1e6 * ny^2 < 998001 * |n|^2  <=>  1999 * ny^2 < 998001 * (nx^2 + nz^2)
    localparam logic [10:0] K_Y  = 11'd1999;
    localparam logic [19:0] K_XZ = 20'd998001;

    localparam logic [QW-1:0] ONE_Q = QW'(64'd1 << OUT_FRAC_BITS);

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } t_vec;

    typedef struct packed {
        logic vld;
        logic hand;
        t_vec v;
    } t_nin;

    typedef struct packed {
        logic               vld;
        logic               hand;
        logic [2:0]         neg;
        logic [2:0][QW-1:0] q;
    } t_nout;

    function automatic logic [MAG_W-1:0] mag_of(input logic [IN_W-1:0] v);
        return v[IN_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [4:0] top_bit(input logic [MAG_W-1:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // Move the magnitude so that bit p lands on bit top; a right move truncates.
    function automatic logic [MAG_W-1:0] scale_mag(input logic [MAG_W-1:0] m,
                                                   input logic [4:0] p, input int top);
        if (int'(p) >= top) begin
            return m >> (int'(p) - top);
        end else begin
            return m << (top - int'(p));
        end
    endfunction

endpackage

### rtl/vtfb_norm.sv
module vtfb_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  vtfb_pkg::t_nin   i_req,
    output vtfb_pkg::t_nout  o_res
);

    typedef struct packed {
        logic                               vld;
        logic                               hand;
        logic [2:0]                         neg;
        logic [2:0][vtfb_pkg::SCL_W-1:0]    m;
    } t_scl;

    typedef struct packed {
        logic                               vld;
        logic                               hand;
        logic [2:0]                         neg;
        logic [2:0][vtfb_pkg::SCL_W-1:0]    m;
        logic [63:0]                        rem;
        logic [63:0]                        res;
    } t_sqs;

    typedef struct packed {
        logic                               vld;
        logic                               hand;
        logic [2:0]                         neg;
        logic [2:0][vtfb_pkg::QW-1:0]       q;
        logic [2:0][vtfb_pkg::NW-1:0]       rem;
        logic [vtfb_pkg::NW-1:0]            d;
    } t_dvs;

    // One bit of the integer square root.
    function automatic t_sqs sq_step(input t_sqs s, input int k);
        logic [64:0] trial;
        logic [63:0] bitv;
        t_sqs        o;
        o     = s;
        bitv  = 64'd1 << (62 - 2 * k);
        trial = {1'b0, s.res} + {1'b0, bitv};
        if ({1'b0, s.rem} >= trial) begin
            o.rem = s.rem - trial[63:0];
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    // One quotient bit of the restoring divide, all three lanes.
    function automatic t_dvs dv_step(input t_dvs s, input int j);
        logic [vtfb_pkg::NW-1:0] dsh;
        t_dvs                    o;
        o   = s;
        dsh = s.d << (vtfb_pkg::QW - 1 - j);
        for (int i = 0; i < 3; i++) begin
            if (s.rem[i] >= dsh) begin
                o.rem[i] = s.rem[i] - dsh;
                o.q[i]   = {s.q[i][vtfb_pkg::QW-2:0], 1'b1};
            end else begin
                o.q[i]   = {s.q[i][vtfb_pkg::QW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    vtfb_pkg::t_nin r_in;
    t_scl           r_sc;
    t_scl           r_m2;
    logic [2:0][2*vtfb_pkg::SCL_W-1:0] r_m2_sq;
    t_sqs           r_sq [vtfb_pkg::SQ_STEPS+1];
    t_dvs           r_dv [vtfb_pkg::QW+1];

    t_scl           n_sc;
    t_sqs           n_sq0;
    t_dvs           n_dv0;

    always_comb begin
        logic [vtfb_pkg::MAG_W-1:0] mx;
        logic [vtfb_pkg::MAG_W-1:0] tmp;
        logic [4:0]                 p;
        mx = r_in.v.mag[0] | r_in.v.mag[1] | r_in.v.mag[2];
        p  = vtfb_pkg::top_bit(mx);
        n_sc.vld  = r_in.vld;
        n_sc.hand = r_in.hand;
        n_sc.neg  = r_in.v.neg;
        for (int i = 0; i < 3; i++) begin
            tmp        = vtfb_pkg::scale_mag(r_in.v.mag[i], p, vtfb_pkg::NRM_TOP);
            n_sc.m[i]  = tmp[vtfb_pkg::SCL_W-1:0];
        end
    end

    always_comb begin
        n_sq0.vld  = r_m2.vld;
        n_sq0.hand = r_m2.hand;
        n_sq0.neg  = r_m2.neg;
        n_sq0.m    = r_m2.m;
        n_sq0.res  = '0;
        n_sq0.rem  = 64'(r_m2_sq[0]) + 64'(r_m2_sq[1]) + 64'(r_m2_sq[2]);
    end

    always_comb begin
        logic [31:0] r;
        r = r_sq[vtfb_pkg::SQ_STEPS].res[31:0];
        if (r == '0) begin
            r = 32'd1;
        end
        n_dv0.vld  = r_sq[vtfb_pkg::SQ_STEPS].vld;
        n_dv0.hand = r_sq[vtfb_pkg::SQ_STEPS].hand;
        n_dv0.neg  = r_sq[vtfb_pkg::SQ_STEPS].neg;
        n_dv0.q    = '0;
        n_dv0.d    = vtfb_pkg::NW'({r, 1'b0});
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = (vtfb_pkg::NW'(r_sq[vtfb_pkg::SQ_STEPS].m[i]) << vtfb_pkg::QW)
                         + vtfb_pkg::NW'(r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
            r_sc.vld <= 1'b0;
            r_m2.vld <= 1'b0;
            for (int k = 0; k <= vtfb_pkg::SQ_STEPS; k++) begin
                r_sq[k].vld <= 1'b0;
            end
            for (int j = 0; j <= vtfb_pkg::QW; j++) begin
                r_dv[j].vld <= 1'b0;
            end
        end else if (i_en) begin
            r_in <= i_req;
            r_sc <= n_sc;
            r_m2 <= r_sc;
            for (int i = 0; i < 3; i++) begin
                r_m2_sq[i] <= r_sc.m[i] * r_sc.m[i];
            end
            r_sq[0] <= n_sq0;
            for (int k = 0; k < vtfb_pkg::SQ_STEPS; k++) begin
                r_sq[k+1] <= sq_step(r_sq[k], k);
            end
            r_dv[0] <= n_dv0;
            for (int j = 0; j < vtfb_pkg::QW; j++) begin
                r_dv[j+1] <= dv_step(r_dv[j], j);
            end
        end
    end

    assign o_res.vld  = r_dv[vtfb_pkg::QW].vld;
    assign o_res.hand = r_dv[vtfb_pkg::QW].hand;
    assign o_res.neg  = r_dv[vtfb_pkg::QW].neg;
    assign o_res.q    = r_dv[vtfb_pkg::QW].q;

endmodule

### rtl/vertex_tangent_frame_builder.sv
// Throughput: one request per cycle while o_stall is low; the 32-step square root and the
// OUT_FRAC_BITS+1 step divider are fully pipelined, one bit per stage.
// A two-entry output buffer lets the pipeline run while a result waits.
// Reset: synchronous, active low; clears all valid bits and the output buffer.
module vertex_tangent_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_has_tangents,
    input  logic signed [31:0] i_normal_x,
    input  logic signed [31:0] i_normal_y,
    input  logic signed [31:0] i_normal_z,
    input  logic signed [31:0] i_tangent_in_x,
    input  logic signed [31:0] i_tangent_in_y,
    input  logic signed [31:0] i_tangent_in_z,
    input  logic signed [31:0] i_bitangent_x,
    input  logic signed [31:0] i_bitangent_y,
    input  logic signed [31:0] i_bitangent_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_unit_tangent_x,
    output logic signed [15:0] o_unit_tangent_y,
    output logic signed [15:0] o_unit_tangent_z,
    output logic        o_handed_negative
);

    localparam int XW = (vtfb_pkg::QW + 1 > vtfb_pkg::OUT_W) ? vtfb_pkg::QW + 1
                                                              : vtfb_pkg::OUT_W;

    typedef struct packed {
        logic           vld;
        logic           n_tiny;
        logic           path_t;
        logic           b_ok;
        vtfb_pkg::t_vec n;
        vtfb_pkg::t_vec t;
    } t_carry;

    function automatic logic is_tiny(input vtfb_pkg::t_vec v);
        logic                             all_low;
        logic [2*vtfb_pkg::TINY_W+1:0]    s;
        logic [2*vtfb_pkg::TINY_W-1:0]    lo;
        logic [2*vtfb_pkg::TINY_W-1:0]    sq;
        all_low = 1'b1;
        s       = '0;
        for (int i = 0; i < 3; i++) begin
            if (v.mag[i][vtfb_pkg::MAG_W-1:vtfb_pkg::TINY_W] != '0) begin
                all_low = 1'b0;
            end
            lo = (2*vtfb_pkg::TINY_W)'(v.mag[i][vtfb_pkg::TINY_W-1:0]);
            sq = lo * lo;
            s  = s + (2*vtfb_pkg::TINY_W+2)'(sq);
        end
        return all_low && (64'(s) <= vtfb_pkg::TINY_SQ);
    endfunction

    function automatic logic signed [vtfb_pkg::RED_W-1:0] reduce_c(
            input logic [vtfb_pkg::MAG_W-1:0] m, input logic neg, input logic [4:0] p);
        logic [vtfb_pkg::MAG_W-1:0]        tmp;
        logic signed [vtfb_pkg::RED_W-1:0] a;
        tmp = vtfb_pkg::scale_mag(m, p, vtfb_pkg::RED_TOP);
        a   = $signed({1'b0, tmp[vtfb_pkg::RED_TOP:0]});
        return neg ? -a : a;
    endfunction

    function automatic logic [vtfb_pkg::OUT_W-1:0] out_val(input logic neg,
                                                           input logic [vtfb_pkg::QW-1:0] q);
        logic [vtfb_pkg::QW-1:0] c;
        logic [XW-1:0]           e;
        c = (q > vtfb_pkg::ONE_Q) ? vtfb_pkg::ONE_Q : q;
        e = XW'(c);
        if (neg) begin
            e = -e;
        end
        return e[vtfb_pkg::OUT_W-1:0];
    endfunction

    logic w_en;
    logic w_fire;

    // stage 1
    logic           r1_vld;
    logic           r1_has;
    vtfb_pkg::t_vec r1_n, r1_t, r1_b;

    // stage 2
    t_carry      r2_c, n2_c;
    logic [63:0] r2_nsq [3];
    logic signed [vtfb_pkg::RED_W-1:0] r2_rt [3], r2_rb [3], r2_rn [3];
    logic signed [vtfb_pkg::RED_W-1:0] n2_rt [3], n2_rb [3], n2_rn [3];

    // stage 3
    t_carry      r3_c;
    logic [63:0] r3_nxz, r3_nyy;
    logic signed [2*vtfb_pkg::RED_W-1:0] r3_p [6];
    logic signed [vtfb_pkg::RED_W-1:0]   r3_rn [3];

    // stage 4
    t_carry      r4_c;
    logic [51:0] r4_xzh, r4_xzl;
    logic [42:0] r4_yh, r4_yl;
    logic signed [2*vtfb_pkg::RED_W:0]   r4_x [3];
    logic signed [vtfb_pkg::RED_W-1:0]   r4_rn [3];

    // stage 5
    t_carry      r5_c;
    logic [85:0] r5_a, r5_b;
    logic signed [63:0] r5_dp [3];

    vtfb_pkg::t_nin  n_nin;
    vtfb_pkg::t_nout w_nout;

    // output buffer
    logic                      r_out_v, r_skid_v;
    logic [vtfb_pkg::OUT_W-1:0] r_ox, r_oy, r_oz, r_sx, r_sy, r_sz;
    logic                      r_oh, r_sh;
    logic [vtfb_pkg::OUT_W-1:0] n_ux, n_uy, n_uz;

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;
    assign w_fire  = r_out_v && !i_stall;

    // tiny tests, handedness reduction
    always_comb begin
        logic [4:0] pt, pb, pn;
        n2_c.vld    = r1_vld;
        n2_c.n_tiny = is_tiny(r1_n);
        n2_c.path_t = r1_has && !is_tiny(r1_t);
        n2_c.b_ok   = !is_tiny(r1_b);
        n2_c.n      = r1_n;
        n2_c.t      = r1_t;
        pt = vtfb_pkg::top_bit(r1_t.mag[0] | r1_t.mag[1] | r1_t.mag[2]);
        pb = vtfb_pkg::top_bit(r1_b.mag[0] | r1_b.mag[1] | r1_b.mag[2]);
        pn = vtfb_pkg::top_bit(r1_n.mag[0] | r1_n.mag[1] | r1_n.mag[2]);
        for (int i = 0; i < 3; i++) begin
            n2_rt[i] = reduce_c(r1_t.mag[i], r1_t.neg[i], pt);
            n2_rb[i] = reduce_c(r1_b.mag[i], r1_b.neg[i], pb);
            n2_rn[i] = reduce_c(r1_n.mag[i], r1_n.neg[i], pn);
        end
        if (n2_c.n_tiny) begin
            n2_rn[0] = '0;
            n2_rn[1] = vtfb_pkg::RED_W'(1) << vtfb_pkg::RED_TOP;
            n2_rn[2] = '0;
        end
    end

    // pick up vector and handedness sign
    always_comb begin
        logic signed [65:0] dsum;
        logic               use_y;
        dsum  = 66'(r5_dp[0]) + 66'(r5_dp[1]) + 66'(r5_dp[2]);
        use_y = r5_a < r5_b;
        n_nin.vld  = r5_c.vld;
        n_nin.hand = r5_c.path_t && r5_c.b_ok && dsum[65];
        priority if (r5_c.path_t) begin
            n_nin.v = r5_c.t;
        end else if (r5_c.n_tiny) begin
            n_nin.v.neg    = 3'b001;
            n_nin.v.mag[0] = vtfb_pkg::MAG_W'(1);
            n_nin.v.mag[1] = '0;
            n_nin.v.mag[2] = '0;
        end else if (use_y) begin
            n_nin.v.neg    = {!r5_c.n.neg[0], 1'b0, r5_c.n.neg[2]};
            n_nin.v.mag[0] = r5_c.n.mag[2];
            n_nin.v.mag[1] = '0;
            n_nin.v.mag[2] = r5_c.n.mag[0];
        end else begin
            n_nin.v.neg    = {1'b0, r5_c.n.neg[0], !r5_c.n.neg[1]};
            n_nin.v.mag[0] = r5_c.n.mag[1];
            n_nin.v.mag[1] = r5_c.n.mag[0];
            n_nin.v.mag[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_c.vld <= 1'b0;
            r3_c.vld <= 1'b0;
            r4_c.vld <= 1'b0;
            r5_c.vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
            r1_has <= i_has_tangents;
            r1_n.neg <= {i_normal_z[31], i_normal_y[31], i_normal_x[31]};
            r1_n.mag <= {vtfb_pkg::mag_of(i_normal_z), vtfb_pkg::mag_of(i_normal_y),
                         vtfb_pkg::mag_of(i_normal_x)};
            r1_t.neg <= {i_tangent_in_z[31], i_tangent_in_y[31], i_tangent_in_x[31]};
            r1_t.mag <= {vtfb_pkg::mag_of(i_tangent_in_z), vtfb_pkg::mag_of(i_tangent_in_y),
                         vtfb_pkg::mag_of(i_tangent_in_x)};
            r1_b.neg <= {i_bitangent_z[31], i_bitangent_y[31], i_bitangent_x[31]};
            r1_b.mag <= {vtfb_pkg::mag_of(i_bitangent_z), vtfb_pkg::mag_of(i_bitangent_y),
                         vtfb_pkg::mag_of(i_bitangent_x)};

            r2_c <= n2_c;
            for (int i = 0; i < 3; i++) begin
                r2_nsq[i] <= 64'(r1_n.mag[i]) * 64'(r1_n.mag[i]);
                r2_rt[i]  <= n2_rt[i];
                r2_rb[i]  <= n2_rb[i];
                r2_rn[i]  <= n2_rn[i];
            end

            r3_c   <= r2_c;
            r3_nxz <= r2_nsq[0] + r2_nsq[2];
            r3_nyy <= r2_nsq[1];
            r3_p[0] <= r2_rt[1] * r2_rb[2];
            r3_p[1] <= r2_rt[2] * r2_rb[1];
            r3_p[2] <= r2_rt[2] * r2_rb[0];
            r3_p[3] <= r2_rt[0] * r2_rb[2];
            r3_p[4] <= r2_rt[0] * r2_rb[1];
            r3_p[5] <= r2_rt[1] * r2_rb[0];
            for (int i = 0; i < 3; i++) begin
                r3_rn[i] <= r2_rn[i];
            end

            r4_c   <= r3_c;
            r4_xzh <= 52'(r3_nxz[63:32]) * 52'(vtfb_pkg::K_XZ);
            r4_xzl <= 52'(r3_nxz[31:0]) * 52'(vtfb_pkg::K_XZ);
            r4_yh  <= 43'(r3_nyy[63:32]) * 43'(vtfb_pkg::K_Y);
            r4_yl  <= 43'(r3_nyy[31:0]) * 43'(vtfb_pkg::K_Y);
            for (int i = 0; i < 3; i++) begin
                r4_x[i]  <= (2*vtfb_pkg::RED_W+1)'(r3_p[2*i])
                          - (2*vtfb_pkg::RED_W+1)'(r3_p[2*i+1]);
                r4_rn[i] <= r3_rn[i];
            end

            r5_c <= r4_c;
            r5_a <= (86'(r4_yh) << 32) + 86'(r4_yl);
            r5_b <= (86'(r4_xzh) << 32) + 86'(r4_xzl);
            for (int i = 0; i < 3; i++) begin
                r5_dp[i] <= r4_x[i] * r4_rn[i];
            end
        end
    end

    vtfb_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (n_nin),
        .o_res   (w_nout)
    );

    assign n_ux = out_val(w_nout.neg[0], w_nout.q[0]);
    assign n_uy = out_val(w_nout.neg[1], w_nout.q[1]);
    assign n_uz = out_val(w_nout.neg[2], w_nout.q[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // pipeline holds; drain the spare entry
            if (w_fire) begin
                r_ox     <= r_sx;
                r_oy     <= r_sy;
                r_oz     <= r_sz;
                r_oh     <= r_sh;
                r_skid_v <= 1'b0;
            end
        end else if (w_nout.vld) begin
            if (!r_out_v || w_fire) begin
                r_ox    <= n_ux;
                r_oy    <= n_uy;
                r_oz    <= n_uz;
                r_oh    <= w_nout.hand;
                r_out_v <= 1'b1;
            end else begin
                r_sx     <= n_ux;
                r_sy     <= n_uy;
                r_sz     <= n_uz;
                r_sh     <= w_nout.hand;
                r_skid_v <= 1'b1;
            end
        end else if (w_fire) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid           = r_out_v;
    assign o_unit_tangent_x  = r_ox;
    assign o_unit_tangent_y  = r_oy;
    assign o_unit_tangent_z  = r_oz;
    assign o_handed_negative = r_oh;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("spare entry full while output register empty");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && o_stall) |=> o_stall)
        else $error("buffer released while result still waiting");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output buffer not cleared by reset");

endmodule

### tb/tb.sv
module tb;

    typedef struct {
        logic               has_t;
        logic signed [31:0] n [3];
        logic signed [31:0] t [3];
        logic signed [31:0] b [3];
    } t_vertex;

    typedef struct {
        logic signed [15:0] u [3];
        logic               neg;
    } t_frame;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint unsigned TINY_LIM = longint'(vtfb_pkg::TINY_SQ);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_has_tangents = 1'b0;
    logic signed [31:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic signed [31:0] i_tangent_in_x = '0, i_tangent_in_y = '0, i_tangent_in_z = '0;
    logic signed [31:0] i_bitangent_x = '0, i_bitangent_y = '0, i_bitangent_z = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [15:0] o_unit_tangent_x, o_unit_tangent_y, o_unit_tangent_z;
    logic        o_handed_negative;

    vertex_tangent_frame_builder i_dut (.*);

    always #5 i_clk = ~i_clk;

    t_vertex pending_vertices [$];
    t_frame  expected_frames [$];
    t_vertex cur_vertex;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_requests = 1'b0;
    int      errors = 0;
    int      quiet_cycles = 0;

    function automatic void add_vertex(t_vertex vx);
        pending_vertices.insert(pending_vertices.size(), vx);
    endfunction

    function automatic void add_frame(t_frame f);
        expected_frames.insert(expected_frames.size(), f);
    endfunction

    function automatic longint unsigned vmag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned sum_sq(longint v [3]);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 3; i++) s += vmag(v[i]) * vmag(v[i]);
        return s;
    endfunction

    // Shift the vector so its largest magnitude has its top bit at 'top'.
    function automatic void scale_vec(input longint v [3], input int top,
                                      output longint unsigned m [3], output bit neg [3]);
        longint unsigned mx;
        int p;
        mx = 0;
        p = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = vmag(v[i]);
            neg[i] = v[i] < 0;
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return;
        while (p < 63 && (mx >> (p + 1)) != 0) p++;
        for (int i = 0; i < 3; i++) begin
            if (p < top) m[i] = m[i] << (top - p);
            else if (p > top) m[i] = m[i] >> (p - top);
        end
    endfunction

    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned res, bm;
        res = 0;
        bm = 64'd1 << 62;
        while (bm > s) bm = bm >> 2;
        while (bm != 0) begin
            if (s >= res + bm) begin
                s = s - (res + bm);
                res = (res >> 1) + bm;
            end else begin
                res = res >> 1;
            end
            bm = bm >> 2;
        end
        return res;
    endfunction

    function automatic void unitize(input longint v [3], output logic signed [15:0] u [3]);
        longint unsigned m [3];
        longint unsigned s, r, q;
        bit neg [3];
        scale_vec(v, 30, m, neg);
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = isqrt(s);
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << (vtfb_pkg::OUT_FRAC_BITS + 1)) + r) / (2 * r);
            if (q > (64'd1 << vtfb_pkg::OUT_FRAC_BITS)) q = 64'd1 << vtfb_pkg::OUT_FRAC_BITS;
            u[i] = neg[i] ? 16'(-q) : 16'(q);
        end
    endfunction

    function automatic void coarse(input longint v [3], output longint r [3]);
        longint unsigned m [3];
        bit neg [3];
        scale_vec(v, 19, m, neg);
        for (int i = 0; i < 3; i++) r[i] = neg[i] ? -longint'(m[i]) : longint'(m[i]);
    endfunction

    function automatic t_frame build_frame(t_vertex vx);
        t_frame f;
        longint n [3], t [3], b [3], c [3], rt [3], rb [3], rn [3];
        longint x0, x1, x2, d;
        logic [127:0] lhs, rhs;
        bit n_tiny;
        for (int i = 0; i < 3; i++) begin
            n[i] = vx.n[i];
            t[i] = vx.t[i];
            b[i] = vx.b[i];
        end
        f.neg = 1'b0;
        n_tiny = sum_sq(n) <= TINY_LIM;
        if (vx.has_t && sum_sq(t) > TINY_LIM) begin
            unitize(t, f.u);
            if (sum_sq(b) > TINY_LIM) begin
                coarse(t, rt);
                coarse(b, rb);
                if (n_tiny) begin
                    rn[0] = 0; rn[1] = 64'd1 << 19; rn[2] = 0;
                end else begin
                    coarse(n, rn);
                end
                x0 = rt[1] * rb[2] - rt[2] * rb[1];
                x1 = rt[2] * rb[0] - rt[0] * rb[2];
                x2 = rt[0] * rb[1] - rt[1] * rb[0];
                d = x0 * rn[0] + x1 * rn[1] + x2 * rn[2];
                f.neg = d < 0;
            end
        end else begin
            if (n_tiny) begin
                c[0] = -1; c[1] = 0; c[2] = 0;
            end else begin
                lhs = 128'(vmag(n[1]) * vmag(n[1])) * 128'd1000000;
                rhs = 128'(sum_sq(n)) * 128'd998001;
                if (lhs < rhs) begin
                    c[0] = n[2]; c[1] = 0; c[2] = -n[0];
                end else begin
                    c[0] = -n[1]; c[1] = n[0]; c[2] = 0;
                end
            end
            if (sum_sq(c) == 0) begin
                f.u[0] = 16'(64'd1 << vtfb_pkg::OUT_FRAC_BITS); f.u[1] = 0; f.u[2] = 0;
            end else begin
                unitize(c, f.u);
            end
        end
        return f;
    endfunction

    function automatic logic signed [31:0] rand_comp();
        logic signed [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $signed($urandom_range(0, 6)) - 3;
            1: v = $urandom;
            2: v = $signed($urandom >> $urandom_range(0, 31));
            default: v = $signed($urandom_range(0, 131072)) - 65536;
        endcase
        if ($urandom_range(0, 1) && v != 0 && $urandom_range(0, 2) != 0) v = -v;
        return v;
    endfunction

    function automatic t_vertex rand_vertex();
        t_vertex vx;
        int big;
        vx.has_t = $urandom_range(0, 3) != 0;
        for (int i = 0; i < 3; i++) begin
            vx.n[i] = rand_comp();
            vx.t[i] = rand_comp();
            vx.b[i] = rand_comp();
        end
        // Steer some normals close to the up-axis switch.
        if ($urandom_range(0, 4) == 0) begin
            big = $urandom_range(1 << 12, 1 << 30);
            vx.n[1] = $urandom_range(0, 1) ? big : -big;
            vx.n[0] = $signed($urandom_range(0, big / 16)) * ($urandom_range(0, 1) ? 1 : -1);
            vx.n[2] = $signed($urandom_range(0, big / 16)) * ($urandom_range(0, 1) ? 1 : -1);
        end
        return vx;
    endfunction

    function automatic t_vertex mk(logic h, int nx, int ny, int nz, int tx, int ty, int tz,
                                   int bx, int by, int bz);
        t_vertex vx;
        vx.has_t = h;
        vx.n[0] = nx; vx.n[1] = ny; vx.n[2] = nz;
        vx.t[0] = tx; vx.t[1] = ty; vx.t[2] = tz;
        vx.b[0] = bx; vx.b[1] = by; vx.b[2] = bz;
        return vx;
    endfunction

    // Driver: present the next request only when the previous one was taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) add_frame(build_frame(cur_vertex));
            if (!i_valid || !o_stall) begin
                if (pending_vertices.size() > 0 && !hold_requests &&
                    $urandom_range(1, 100) > send_idle_pct) begin
                    cur_vertex <= pending_vertices[0];
                    i_has_tangents <= pending_vertices[0].has_t;
                    i_normal_x <= pending_vertices[0].n[0];
                    i_normal_y <= pending_vertices[0].n[1];
                    i_normal_z <= pending_vertices[0].n[2];
                    i_tangent_in_x <= pending_vertices[0].t[0];
                    i_tangent_in_y <= pending_vertices[0].t[1];
                    i_tangent_in_z <= pending_vertices[0].t[2];
                    i_bitangent_x <= pending_vertices[0].b[0];
                    i_bitangent_y <= pending_vertices[0].b[1];
                    i_bitangent_z <= pending_vertices[0].b[2];
                    void'(pending_vertices.pop_front());
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction.
    always @(posedge i_clk) begin
        t_frame e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected result %0d %0d %0d %0b", $time,
                             o_unit_tangent_x, o_unit_tangent_y, o_unit_tangent_z,
                             o_handed_negative);
                    errors++;
                end else begin
                    e = expected_frames.pop_front();
                    if (e.u[0] !== o_unit_tangent_x || e.u[1] !== o_unit_tangent_y ||
                        e.u[2] !== o_unit_tangent_z || e.neg !== o_handed_negative) begin
                        $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b", $time,
                                 e.u[0], e.u[1], e.u[2], e.neg, o_unit_tangent_x,
                                 o_unit_tangent_y, o_unit_tangent_z, o_handed_negative);
                        errors++;
                    end
                end
            end
            i_stall <= $urandom_range(1, 100) <= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int send_pct [4] = '{0, 48, 0, 29};
        int recv_pct [4] = '{0, 0, 48, 29};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_vertex(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(1, 0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        add_vertex(mk(1, 0, 65536, 0, 65536, 0, 0, 0, 0, 65536));
        add_vertex(mk(1, 0, 65536, 0, 65536, 0, 0, 0, 0, -65536));
        add_vertex(mk(1, 0, 0, 65536, 5, 4, 1, 65536, 0, 0));
        add_vertex(mk(1, 0, 0, 65536, 5, 3, 3, 5, 3, 3));
        add_vertex(mk(1, 0, 0, 65536, 65536, 0, 0, 5, 4, 1));
        add_vertex(mk(0, 5, 4, 1, 1, 1, 1, 1, 1, 1));
        add_vertex(mk(0, 5, 3, 3, 1, 1, 1, 1, 1, 1));
        add_vertex(mk(0, 0, 65536, 0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(0, 0, -65536, 0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(0, 2927, 65536, 0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(0, 2933, 65536, 0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(0, 65536, 0, 0, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
            32'h7fffffff));
        add_vertex(mk(1, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000));
        add_vertex(mk(0, 32'h80000000, 32'h80000000, 32'h80000000,
            0, 0, 0, 0, 0, 0));
        add_vertex(mk(0, 32'h7fffffff, 0, 32'h80000000, 0, 0, 0, 0, 0, 0));
        add_vertex(mk(1, 1, 0, 0, 32'h80000000, 0, 0, 0, 0, 32'h7fffffff));
        add_vertex(mk(1, -1, -1, -1, -1, 1, -1, 1, -1, 1));

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int k = 0; k < 225; k++) add_vertex(rand_vertex());
            while (pending_vertices.size() > 0) @(posedge i_clk);
            if (ph == 1) begin
                // Hold off new requests until the pipeline has drained.
                hold_requests = 1'b1;
                while (expected_frames.size() > 0 || i_valid) @(posedge i_clk);
                hold_requests = 1'b0;
            end
        end
        while (i_valid || expected_frames.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### sim.f
rtl/vtfb_pkg.sv
rtl/vtfb_norm.sv
rtl/vertex_tangent_frame_builder.sv
tb/tb.sv
